[hw/rtl/tsa_pkg.sv]
// Package for the three-state automaton step: types, constants and scoring function.
`default_nettype none
package tsa_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int COL_W     = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W     = 16;
	localparam int EMIT_W    = $clog2(MAX_WIDTH * 65535 + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int GW_W      = 11;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	typedef logic [1:0] code_t;

	localparam code_t CODE_EMPTY = 2'd0;
	localparam code_t CODE_LIGHT = 2'd1;
	localparam code_t CODE_DARK  = 2'd2;

	typedef struct packed {
		code_t top;
		code_t mid;
		code_t bot;
	} col_t;

	typedef struct packed {
		code_t older;
		code_t newer;
	} lb_entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bot;
	} border_t;

	function automatic col_t mask_col(col_t c, logic all_m, logic top_m, logic bot_m);
		col_t r;
		r = c;
		if (all_m) begin
			r = '0;
		end
		if (top_m) begin
			r.top = CODE_EMPTY;
		end
		if (bot_m) begin
			r.bot = CODE_EMPTY;
		end
		return r;
	endfunction

	function automatic logic is_dark(col_t c);
		return (c.top == CODE_DARK) || (c.mid == CODE_DARK) || (c.bot == CODE_DARK);
	endfunction

	function automatic code_t score_cell(col_t l, col_t c, col_t r);
		logic       dark;
		logic [2:0] k;
		logic [3:0] tri_v;
		logic [3:0] score;
		dark = is_dark(l) || is_dark(c) || is_dark(r);
		k = {2'b0, l.top == CODE_LIGHT} + {2'b0, r.top == CODE_LIGHT}
			+ {2'b0, l.bot == CODE_LIGHT} + {2'b0, r.bot == CODE_LIGHT};
		unique case (k)
			3'd0, 3'd1: tri_v = 4'd0;
			3'd2:       tri_v = 4'd1;
			3'd3:       tri_v = 4'd3;
			default:    tri_v = 4'd6;
		endcase
		score = {3'b0, dark} + {3'b0, c.mid == CODE_LIGHT} + tri_v;
		if (score == 4'd1) begin
			return CODE_LIGHT;
		end else if (score == 4'd2) begin
			return CODE_DARK;
		end
		return CODE_EMPTY;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tsa_if.sv]
// Channel interfaces: cell input, result output and configuration write.
`default_nettype none
interface tsa_cell_if;
	logic              valid;
	logic              ready;
	tsa_pkg::code_t    cell_code;
	logic              flush;
	modport source (output valid, output cell_code, output flush, input ready);
	modport sink   (input valid, input cell_code, input flush, output ready);
endinterface

interface tsa_result_if;
	logic              valid;
	logic              ready;
	tsa_pkg::code_t    new_cell;
	logic              last_of_frame;
	modport source (output valid, output new_cell, output last_of_frame, input ready);
	modport sink   (input valid, input new_cell, input last_of_frame, output ready);
endinterface

interface tsa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tsa_pkg::CFG_IDX_W-1:0]    index;
	logic [tsa_pkg::CFG_DAT_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tsa_line_buf.sv]
// Two-row line buffer: one memory of {older, newer} entries with registered read.
`default_nettype none
module tsa_line_buf (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [tsa_pkg::ADDR_W-1:0]   rd_addr,
	output tsa_pkg::lb_entry_t                rd_q,
	input  wire logic                         wr_en,
	input  wire logic [tsa_pkg::ADDR_W-1:0]   wr_addr,
	input  wire tsa_pkg::lb_entry_t           wr_data
);

	tsa_pkg::lb_entry_t mem_q [tsa_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// same-address write in this cycle wins
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tsa_col_cell.sv]
// Window column cell: holds one 3-cell column and passes it to its left neighbor.
`default_nettype none
module tsa_col_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tsa_pkg::cell_ctl_t ctl,
	input  wire tsa_pkg::col_t      col_in,
	output tsa_pkg::col_t           col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			if (ctl.clear) begin
				col_q <= '0;
			end else begin
				col_q <= col_in;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/three_state_automaton_step.sv]
// Top level of the three-state automaton step: counters, line buffer, window cells, output.
//
// Usage: cells of the previous generation enter on the cells channel in raster order,
// one request per cycle while cells.ready is high, grid_width * grid_height grid
// items followed by grid_width + 1 items (flush set or not) that drain the last row.
// Each item from row 1, column 1 onward yields one request on the results channel;
// the final one carries last_of_frame, after which a new frame starts with the next item.
// A result passes through the read stage and then the output register after the item
// that completes its window is accepted. Throughput: one item per cycle while cells.ready
// is high; the line buffer reads an entry at accept and writes it back on its own port
// when the item leaves the read stage. Configuration: cfg writes are always taken;
// index 0 is grid_width, 1 is grid_height. After each write the cells channel holds
// ready low in the next cycle while the frame size product is recomputed.
// Reset: counters and window clear to an empty frame; widths return to 256 x 256.
// The line buffer is not cleared, its stale entries only feed masked borders.
// When results is stalled, one result waits in the output register and one more
// item can be held in the read stage; after that cells.ready drops.
`default_nettype none
module three_state_automaton_step (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tsa_cell_if.sink      cells,
	tsa_result_if.source  results,
	tsa_cfg_if.sink       cfg
);

	localparam int COL_W  = tsa_pkg::COL_W;
	localparam int ROW_W  = tsa_pkg::ROW_W;
	localparam int EMIT_W = tsa_pkg::EMIT_W;
	localparam int ADDR_W = tsa_pkg::ADDR_W;

	// configuration
	logic [COL_W-1:0]  w_eff_q;
	logic [ROW_W-1:0]  h_eff_q;
	logic [EMIT_W-1:0] total_q;
	logic              cfg_wait_q;
	logic [tsa_pkg::GW_W-1:0] gw_raw;
	logic [ROW_W-1:0]  gh_raw;

	// position counters; the row runs past the grid height while draining
	logic [COL_W-1:0]  col_q;
	logic [ROW_W:0]    row_q;
	logic [EMIT_W-1:0] emitted_q;

	// accept-stage logic
	logic              accept;
	logic              wrap;
	logic [COL_W-1:0]  ci;
	logic [ROW_W:0]    ri;
	tsa_pkg::code_t    v;
	logic              ci_nz;
	logic              emit;
	tsa_pkg::border_t  border;
	logic [EMIT_W-1:0] e_next;
	logic              last;

	// read stage
	logic              v_s1;
	tsa_pkg::code_t    code_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              emit_s1;
	logic              last_s1;
	tsa_pkg::border_t  border_s1;
	tsa_pkg::lb_entry_t rd_q;
	logic              s1_go;

	// output stage
	logic              v_s2;
	tsa_pkg::code_t    cell_s2;
	logic              last_s2;
	logic              s2_free;

	// window
	tsa_pkg::cell_ctl_t ctl;
	tsa_pkg::col_t      new_col;
	tsa_pkg::col_t      col1_q;
	tsa_pkg::col_t      col2_q;
	tsa_pkg::code_t     score;

	assign gw_raw = cfg.data[tsa_pkg::GW_W-1:0];
	assign gh_raw = cfg.data[ROW_W-1:0];
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q    <= COL_W'(256);
			h_eff_q    <= ROW_W'(256);
			total_q    <= EMIT_W'(256 * 256);
			cfg_wait_q <= 1'b0;
		end else begin
			cfg_wait_q <= cfg.valid;
			total_q    <= EMIT_W'({{ROW_W{1'b0}}, w_eff_q} * {{COL_W{1'b0}}, h_eff_q});
			if (cfg.valid) begin
				unique case (cfg.index)
					tsa_pkg::REG_GRID_WIDTH: begin
						if (gw_raw < tsa_pkg::GW_W'(3)) begin
							w_eff_q <= COL_W'(3);
						end else if (32'(gw_raw) > tsa_pkg::MAX_WIDTH) begin
							w_eff_q <= COL_W'(tsa_pkg::MAX_WIDTH);
						end else begin
							w_eff_q <= COL_W'(gw_raw);
						end
					end
					tsa_pkg::REG_GRID_HEIGHT: begin
						h_eff_q <= (gh_raw < ROW_W'(2)) ? ROW_W'(2) : gh_raw;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// handshake
	assign s2_free      = !v_s2 || results.ready;
	assign s1_go        = v_s1 && (!emit_s1 || s2_free);
	assign cells.ready  = (!v_s1 || s1_go) && !cfg_wait_q;
	assign accept       = cells.valid && cells.ready;

	// position of the incoming item and its border flags
	always_comb begin
		wrap  = col_q >= w_eff_q;
		ci    = wrap ? '0 : col_q;
		ri    = wrap ? row_q + (ROW_W+1)'(1) : row_q;
		v     = (cells.flush || (ri >= {1'b0, h_eff_q})) ? tsa_pkg::CODE_EMPTY
			: cells.cell_code;
		ci_nz = ci != '0;
		emit  = (ri >= (ROW_W+1)'(2)) || ((ri == (ROW_W+1)'(1)) && ci_nz);
		border.left  = ci == COL_W'(1);
		border.right = !ci_nz;
		border.top   = ci_nz ? (ri == (ROW_W+1)'(1)) : (ri == (ROW_W+1)'(2));
		border.bot   = ci_nz ? (ri >= {1'b0, h_eff_q})
			: (ri >= ({1'b0, h_eff_q} + (ROW_W+1)'(1)));
		e_next = emitted_q + EMIT_W'(1);
		last   = emit && (e_next >= total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (accept) begin
			if (last) begin
				col_q     <= '0;
				row_q     <= '0;
				emitted_q <= '0;
			end else begin
				col_q <= ci + COL_W'(1);
				row_q <= ri;
				if (emit) begin
					emitted_q <= e_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1   <= v;
			addr_s1   <= ci[ADDR_W-1:0];
			emit_s1   <= emit;
			last_s1   <= last;
			border_s1 <= border;
		end
	end

	tsa_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (ci[ADDR_W-1:0]),
		.rd_q    (rd_q),
		.wr_en   (s1_go),
		.wr_addr (addr_s1),
		.wr_data ({rd_q.newer, code_s1})
	);

	// window: incoming column, then two stored columns shifting left
	assign new_col   = '{top: rd_q.older, mid: rd_q.newer, bot: code_s1};
	assign ctl.shift = s1_go;
	assign ctl.clear = last_s1;

	tsa_col_cell u_cell_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.col_in (new_col),
		.col_q  (col2_q)
	);

	tsa_col_cell u_cell_center (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.col_in (col2_q),
		.col_q  (col1_q)
	);

	assign score = tsa_pkg::score_cell(
		tsa_pkg::mask_col(col1_q, border_s1.left, border_s1.top, border_s1.bot),
		tsa_pkg::mask_col(col2_q, 1'b0, border_s1.top, border_s1.bot),
		tsa_pkg::mask_col(new_col, border_s1.right, border_s1.top, border_s1.bot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_go && emit_s1) begin
			v_s2 <= 1'b1;
		end else if (results.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			cell_s2 <= score;
			last_s2 <= last_s1;
		end
	end

	assign results.valid         = v_s2;
	assign results.new_cell      = cell_s2;
	assign results.last_of_frame = last_s2;

`ifndef NO_ASSERTIONS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(tsa_pkg::MAX_WIDTH))
		else $error("column counter beyond line buffer depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_go) |-> (emit_s1 && v_s2 && !results.ready))
		else $error("read stage held without a blocked output");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (col_q == '0 && row_q == '0 && emitted_q == '0))
		else $error("counters not cleared at frame end");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (col1_q == '0 && col2_q == '0))
		else $error("window not cleared at frame end");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |-> emit_s1)
		else $error("frame end flagged on an item without result");
`endif

endmodule
`default_nettype wire

[verif/tb_three_state_automaton_step.sv]
`timescale 1ns / 100ps
// Testbench for the three-state automaton step: directed table and random frames vs. predictor.
module tb_three_state_automaton_step;

	typedef tsa_pkg::code_t code_t;

	localparam int    MAX_WIDTH  = tsa_pkg::MAX_WIDTH;
	localparam int    GW_W       = tsa_pkg::GW_W;
	localparam code_t CODE_EMPTY = tsa_pkg::CODE_EMPTY;
	localparam code_t CODE_LIGHT = tsa_pkg::CODE_LIGHT;
	localparam code_t CODE_DARK  = tsa_pkg::CODE_DARK;
	localparam logic [tsa_pkg::CFG_IDX_W-1:0] REG_GRID_WIDTH  = tsa_pkg::REG_GRID_WIDTH;
	localparam logic [tsa_pkg::CFG_IDX_W-1:0] REG_GRID_HEIGHT = tsa_pkg::REG_GRID_HEIGHT;

	localparam code_t       CODE_UNUSED   = 2'd3;
	localparam logic [15:0] NO_VAL        = 16'd0;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          DIRECTED_ROWS = 25;

	typedef struct packed {
		code_t state;
		logic  is_last;
	} gen_cell_t;

	typedef struct packed {
		code_t       in_code;
		logic        in_flush;
		logic        reconfig;
		logic [15:0] width_val;
		logic [15:0] height_val;
		logic        known;
		logic        exp_valid;
		code_t       exp_state;
		logic        exp_last;
	} directed_row_t;

	logic clk;
	logic arst_n;

	tsa_cell_if   cell_bus ();
	tsa_result_if result_bus ();
	tsa_cfg_if    cfg_bus ();

	three_state_automaton_step dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cells   (cell_bus),
		.results (result_bus),
		.cfg     (cfg_bus)
	);

	// predictor state
	code_t       row_older [MAX_WIDTH] = '{default: CODE_EMPTY};
	code_t       row_newer [MAX_WIDTH] = '{default: CODE_EMPTY};
	code_t       win [3][3] = '{default: CODE_EMPTY}; // [left, center, right][top, mid, bottom]
	int unsigned pred_col = 0;
	int unsigned pred_row = 0;
	int unsigned pred_emitted = 0;
	logic [GW_W-1:0] grid_width_reg  = 11'd256;
	logic [15:0]     grid_height_reg = 16'd256;

	gen_cell_t   next_gen_q [$];
	int unsigned mismatches = 0;
	int          send_gap_max = 14;
	int          recv_gap_max = 14;

	// frame 1: all neighborhoods hold nothing live, so every result is empty
	// frame 2: tall grid, then width and height shrink mid-frame and the frame ends early
	directed_row_t directed [DIRECTED_ROWS] = '{
		'{CODE_UNUSED, 1'b0, 1'b1, 16'd0,  16'd1,  1'b1, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b1, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_UNUSED, 1'b0, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_UNUSED, 1'b1, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b1, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b0, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b0},
		'{CODE_UNUSED, 1'b1, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b0, 1'b0, NO_VAL, NO_VAL, 1'b1, 1'b1, CODE_EMPTY, 1'b1},
		'{CODE_LIGHT,  1'b0, 1'b1, 16'd5,  16'hFFFF, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b1, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_EMPTY,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_LIGHT,  1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_UNUSED, 1'b0, 1'b0, NO_VAL, NO_VAL, 1'b0, 1'b0, CODE_EMPTY, 1'b0},
		'{CODE_DARK,   1'b0, 1'b1, 16'd3,  16'd0,  1'b0, 1'b0, CODE_EMPTY, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned grid_cols();
		if (grid_width_reg < 3) return 3;
		if (grid_width_reg > MAX_WIDTH) return MAX_WIDTH;
		return grid_width_reg;
	endfunction

	function automatic int unsigned grid_rows();
		return (grid_height_reg < 2) ? 2 : grid_height_reg;
	endfunction

	// advances the predicted line buffers and window by one cell; 1 when a result is due
	function automatic bit next_generation_cell(input code_t in_code, input logic in_flush,
			output gen_cell_t outcome);
		int unsigned cols, rows, ci, ri, cc, rc;
		int          s, r, corners, score;
		code_t       v, top, mid, c;
		logic        dark, center_light;
		cols = grid_cols();
		rows = grid_rows();
		outcome = '0;
		if (pred_col >= cols) begin
			pred_col = 0;
			pred_row++;
		end
		ci = pred_col;
		ri = pred_row;
		v = (in_flush || ri >= rows) ? CODE_EMPTY : in_code;
		top = row_older[ci];
		mid = row_newer[ci];
		row_older[ci] = mid;
		row_newer[ci] = v;
		for (r = 0; r < 3; r++) begin
			win[0][r] = win[1][r];
			win[1][r] = win[2][r];
		end
		win[2][0] = top;
		win[2][1] = mid;
		win[2][2] = v;
		pred_col++;
		if (ri == 0 || (ri == 1 && ci == 0)) return 1'b0;
		// window center sits one cell back, wrapping to the previous row at column 0
		cc = (ci != 0) ? ci - 1 : cols - 1;
		rc = (ci != 0) ? ri - 1 : ri - 2;
		dark = 1'b0;
		center_light = 1'b0;
		corners = 0;
		for (s = 0; s < 3; s++) begin
			for (r = 0; r < 3; r++) begin
				c = win[s][r];
				if ((s == 0 && cc == 0) || (s == 2 && cc >= cols - 1)
						|| (r == 0 && rc == 0) || (r == 2 && rc >= rows - 1)) begin
					c = CODE_EMPTY;
				end
				if (c == CODE_DARK) dark = 1'b1;
				if (c == CODE_LIGHT) begin
					if (s == 1 && r == 1) center_light = 1'b1;
					else if (s != 1 && r != 1) corners++;
				end
			end
		end
		score = int'(dark) + int'(center_light) + (corners * (corners - 1)) / 2;
		outcome.state = (score == 1) ? CODE_LIGHT : (score == 2) ? CODE_DARK : CODE_EMPTY;
		pred_emitted++;
		outcome.is_last = (pred_emitted >= cols * rows);
		if (outcome.is_last) begin
			pred_col = 0;
			pred_row = 0;
			pred_emitted = 0;
			win = '{default: CODE_EMPTY};
		end
		return 1'b1;
	endfunction

	task automatic send_cell(input code_t in_code, input logic in_flush,
			output bit produced, output gen_cell_t outcome);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			cell_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_bus.valid     <= 1'b1;
		cell_bus.cell_code <= in_code;
		cell_bus.flush     <= in_flush;
		do @(posedge clk); while (!cell_bus.ready);
		produced = next_generation_cell(in_code, in_flush, outcome);
	endtask

	task automatic settle_pipeline();
		cell_bus.valid <= 1'b0;
		while (next_gen_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic [15:0] width_val, input logic [15:0] height_val);
		settle_pipeline();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= REG_GRID_WIDTH;
		cfg_bus.data  <= width_val;
		do @(posedge clk); while (!cfg_bus.ready);
		grid_width_reg = width_val[GW_W-1:0];
		cfg_bus.index <= REG_GRID_HEIGHT;
		cfg_bus.data  <= height_val;
		do @(posedge clk); while (!cfg_bus.ready);
		grid_height_reg = height_val;
		cfg_bus.valid <= 1'b0;
	endtask

	// result sink: random stalls, with stretches of none
	initial begin : result_sink
		int          gap;
		int unsigned taken;
		taken = 0;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (gap > 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
			taken++;
			if (taken % 40 == 0) recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
		end
	end

	always @(posedge clk) begin : check_result
		gen_cell_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (next_gen_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected request: new_cell=%0d last_of_frame=%0b",
						$time, result_bus.new_cell, result_bus.last_of_frame);
				end
			end else begin
				want = next_gen_q.pop_front();
				if (want.state !== result_bus.new_cell
						|| want.is_last !== result_bus.last_of_frame) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected new_cell=%0d last_of_frame=%0b, got %0d %0b",
							$time, want.state, want.is_last,
							result_bus.new_cell, result_bus.last_of_frame);
					end
				end
			end
		end
	end

	initial begin
		bit          produced;
		gen_cell_t   outcome;
		int          row, i, pick, dark_pct, flush_pct, frame_no;
		int unsigned random_items, frame_cells, frame_items;
		logic [15:0] width_val, height_val;
		code_t       in_code;
		logic        in_flush;

		arst_n             <= 1'b0;
		cell_bus.valid     <= 1'b0;
		cell_bus.cell_code <= CODE_EMPTY;
		cell_bus.flush     <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= REG_GRID_WIDTH;
		cfg_bus.data       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed[row].reconfig) begin
				set_grid(directed[row].width_val, directed[row].height_val);
			end
			send_cell(directed[row].in_code, directed[row].in_flush, produced, outcome);
			if (directed[row].known) begin
				produced        = directed[row].exp_valid;
				outcome.state   = directed[row].exp_state;
				outcome.is_last = directed[row].exp_last;
			end
			if (produced) next_gen_q.push_back(outcome);
		end

		frame_no = 0;
		random_items = 0;
		while (random_items < 450) begin
			if (frame_no == 3) begin
				// register bits above the field set; only the low field bits count
				width_val  = 16'hF805;
				height_val = 16'd2;
			end else begin
				width_val  = 16'($urandom_range(3, ($urandom_range(0, 4) == 0) ? 16 : 8));
				height_val = 16'($urandom_range(2, 6));
			end
			set_grid(width_val, height_val);
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
			dark_pct     = $urandom_range(0, 20);
			flush_pct    = ($urandom_range(0, 5) == 0) ? 50 : 5;
			frame_cells  = grid_cols() * grid_rows();
			frame_items  = frame_cells + grid_cols() + 1;
			for (i = 0; i < frame_items; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < dark_pct) in_code = CODE_DARK;
				else if (pick < dark_pct + 5) in_code = CODE_UNUSED;
				else if (pick < dark_pct + 55) in_code = CODE_LIGHT;
				else in_code = CODE_EMPTY;
				if (i < frame_cells) in_flush = ($urandom_range(0, 99) < flush_pct);
				else in_flush = 1'($urandom_range(0, 1));
				send_cell(in_code, in_flush, produced, outcome);
				if (produced) next_gen_q.push_back(outcome);
				random_items++;
			end
			frame_no++;
		end

		settle_pipeline();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tsa_pkg.sv
hw/rtl/tsa_if.sv
hw/rtl/tsa_line_buf.sv
hw/rtl/tsa_col_cell.sv
hw/rtl/three_state_automaton_step.sv
verif/tb_three_state_automaton_step.sv
